### rtl/lrf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_pkg: shared types and constants of the line-fit core
// Status codes, arithmetic unit commands and fixed output formats.
// ----------------------------------------------------------------------------
package lrf_pkg;

    // fit status codes
    typedef enum logic [1:0] {
        FS_OK      = 2'd0,
        FS_X_CONST = 2'd1,
        FS_Y_CONST = 2'd2,
        FS_EXCESS  = 2'd3
    } t_fit_status;

    // arithmetic unit operations
    typedef enum logic {
        MD_MUL = 1'b0,
        MD_DIV = 1'b1
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_cmd;

    typedef struct packed {
        logic done;
    } t_md_stat;

    // output formats
    localparam int OUT_W       = 48;
    localparam int CORR_W      = 32;
    localparam int SAT_BIT     = 47;
    localparam int FRAC_SHIFT  = 17;   // 2^16 scale with a half for rounding
    localparam int CORR_SHIFT  = 62;   // (2^31)^2 for the squared correlation
    localparam int CORR_ONE    = 30;
    localparam int Q_W         = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int SQ_CNT_W    = 5;
    localparam int SQ_REM_W    = 36;
    localparam int QUEUE_DEPTH = 4;

endpackage
`default_nettype wire

### rtl/linear_regression_fit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// linear_regression_fit_core: streaming least-squares line fit
// Throughput: one sample pair per cycle into the two-stage accumulator pipe
// while o_in_stall is low. A full fit uses the shared multiply/divide unit
// for eight sum products, two wide products and three restoring divides,
// then takes 32 root steps in the sequencer.
// Reset: synchronous, clears sums, count, queue and sequencer at once.
// ----------------------------------------------------------------------------
module linear_regression_fit_core #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [23:0]        i_x_sample,
    input  wire logic [23:0]        i_y_sample,
    input  wire logic               i_is_last,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic signed [31:0]      o_correlation,
    output logic signed [47:0]      o_slope,
    output logic signed [47:0]      o_intercept,
    output logic [1:0]              o_fit_status
);
    import lrf_pkg::*;

    localparam int N_W   = $clog2(MAX_SAMPLES + 2);
    localparam int S1_W  = SAMPLE_BITS + $clog2(MAX_SAMPLES + 1);
    localparam int S2_W  = 2 * SAMPLE_BITS + $clog2(MAX_SAMPLES + 1);
    localparam int D_W   = N_W + S2_W;
    localparam int WW    = 2 * D_W + CORR_SHIFT + 2;
    localparam int REC_W = 1 + N_W + 2 * S1_W + 3 * S2_W;

    logic             push, pop, empty, hold;
    logic [REC_W-1:0] rec_in, rec_out;
    t_md_cmd          md_cmd;
    t_md_stat         md_stat;
    logic [WW-1:0]    md_a, md_b, md_res;

    assign o_in_stall = hold;

    // accumulator
    lrf_front #(
        .MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SAMPLE_BITS),
        .N_W(N_W), .S1_W(S1_W), .S2_W(S2_W), .REC_W(REC_W)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_in_valid),
        .i_x_sample(i_x_sample), .i_y_sample(i_y_sample), .i_is_last(i_is_last),
        .i_hold(hold), .o_push(push), .o_rec(rec_in)
    );

    // snapshot queue
    lrf_queue #(.W(REC_W)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_din(rec_in),
        .i_pop(pop), .o_dout(rec_out), .o_empty(empty), .o_hold(hold)
    );

    // shared wide arithmetic
    lrf_muldiv #(.WW(WW)) u_muldiv (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(md_cmd), .i_op_a(md_a),
        .i_op_b(md_b), .o_stat(md_stat), .o_result(md_res)
    );

    // fit sequencer
    lrf_back #(
        .N_W(N_W), .S1_W(S1_W), .S2_W(S2_W), .WW(WW), .REC_W(REC_W)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_rec(rec_out), .i_empty(empty),
        .o_pop(pop), .o_cmd(md_cmd), .o_op_a(md_a), .o_op_b(md_b),
        .i_stat(md_stat), .i_result(md_res), .o_valid(o_out_valid),
        .i_stall(i_out_stall), .o_correlation(o_correlation), .o_slope(o_slope),
        .o_intercept(o_intercept), .o_fit_status(o_fit_status)
    );

endmodule
`default_nettype wire

### rtl/lrf_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_front: sample accumulator
// Squares and products in one stage, exact sums in the next; a last pair
// sends a snapshot of the sums to the queue and clears them.
// ----------------------------------------------------------------------------
module lrf_front #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 24,
    parameter int N_W         = 11,
    parameter int S1_W        = 35,
    parameter int S2_W        = 59,
    parameter int REC_W       = 259
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire logic [23:0]      i_x_sample,
    input  wire logic [23:0]      i_y_sample,
    input  wire logic             i_is_last,
    input  wire logic             i_hold,
    output logic                  o_push,
    output logic [REC_W-1:0]      o_rec
);
    import lrf_pkg::*;

    localparam int P_W = 2 * SAMPLE_BITS;
    localparam logic [N_W-1:0] CNT_MAX  = N_W'(MAX_SAMPLES);
    localparam logic [N_W-1:0] CNT_OVER = N_W'(MAX_SAMPLES + 1);

    logic                   accept;
    logic                   r_s1_v;
    logic                   r_s1_last;
    logic [SAMPLE_BITS-1:0] r_x, r_y;
    logic [P_W-1:0]         r_xx, r_yy, r_xy;

    logic [N_W-1:0]  r_cnt, n_cnt;
    logic [S1_W-1:0] r_sx, r_sy, n_sx, n_sy;
    logic [S2_W-1:0] r_sxx, r_syy, r_sxy, n_sxx, n_syy, n_sxy;
    logic            add;

    assign accept = i_valid && !i_hold;

    // product stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= accept;
        end
        if (accept) begin
            r_s1_last <= i_is_last;
            r_x       <= i_x_sample[SAMPLE_BITS-1:0];
            r_y       <= i_y_sample[SAMPLE_BITS-1:0];
            r_xx      <= i_x_sample[SAMPLE_BITS-1:0] * i_x_sample[SAMPLE_BITS-1:0];
            r_yy      <= i_y_sample[SAMPLE_BITS-1:0] * i_y_sample[SAMPLE_BITS-1:0];
            r_xy      <= i_x_sample[SAMPLE_BITS-1:0] * i_y_sample[SAMPLE_BITS-1:0];
        end
    end

    // running sums, held once the count limit is passed
    always_comb begin
        add   = r_cnt < CNT_MAX;
        n_cnt = add ? r_cnt + N_W'(1) : CNT_OVER;
        n_sx  = add ? r_sx + S1_W'(r_x) : r_sx;
        n_sy  = add ? r_sy + S1_W'(r_y) : r_sy;
        n_sxx = add ? r_sxx + S2_W'(r_xx) : r_sxx;
        n_syy = add ? r_syy + S2_W'(r_yy) : r_syy;
        n_sxy = add ? r_sxy + S2_W'(r_xy) : r_sxy;
    end

    assign o_push = r_s1_v && r_s1_last;
    assign o_rec  = {!add, n_cnt, n_sx, n_sy, n_sxx, n_syy, n_sxy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (r_s1_v && r_s1_last)) begin
            r_cnt <= '0;
            r_sx  <= '0;
            r_sy  <= '0;
            r_sxx <= '0;
            r_syy <= '0;
            r_sxy <= '0;
        end else if (r_s1_v) begin
            r_cnt <= n_cnt;
            r_sx  <= n_sx;
            r_sy  <= n_sy;
            r_sxx <= n_sxx;
            r_syy <= n_syy;
            r_sxy <= n_sxy;
        end
    end

endmodule
`default_nettype wire

### rtl/lrf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_queue: short queue of sum snapshots
// Decouples the accumulator from the fit engine; holds off new requests
// once no more than one slot is left, which is kept for the pair in flight.
// ----------------------------------------------------------------------------
module lrf_queue #(
    parameter int W = 259
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_din,
    input  wire logic         i_pop,
    output logic [W-1:0]      o_dout,
    output logic              o_empty,
    output logic              o_hold
);
    import lrf_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [W-1:0]     r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_pop;

    assign o_empty = r_cnt == '0;
    assign o_hold  = r_cnt >= CNT_W'(QUEUE_DEPTH - 1);
    assign o_dout  = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PTR_W'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(do_pop);
        end
    end

endmodule
`default_nettype wire

### rtl/lrf_muldiv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_muldiv: iterative wide multiplier and divider
// Shift-and-add multiply ending when the multiplier runs out of ones;
// restoring divide giving one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrf_muldiv #(
    parameter int WW = 212
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lrf_pkg::t_md_cmd  i_cmd,
    input  wire logic [WW-1:0]     i_op_a,
    input  wire logic [WW-1:0]     i_op_b,
    output lrf_pkg::t_md_stat      o_stat,
    output logic [WW-1:0]          o_result
);
    import lrf_pkg::*;

    localparam int CW = $clog2(WW);

    logic          r_act, r_done;
    t_md_op        r_op;
    logic [WW-1:0] r_a, r_b, r_acc, r_rem;
    logic [CW-1:0] r_cnt;
    logic [WW:0]   rem_sh;
    logic          ge;

    // trial subtraction of the divide step
    always_comb begin
        rem_sh = {r_rem, r_a[WW-1]};
        ge     = rem_sh >= {1'b0, r_b};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_act <= 1'b1;
                r_op  <= i_cmd.op;
                r_a   <= i_op_a;
                r_b   <= i_op_b;
                r_acc <= '0;
                r_rem <= '0;
                r_cnt <= '0;
            end else if (r_act) begin
                if (r_op == MD_MUL) begin
                    if (r_b == '0) begin
                        r_act  <= 1'b0;
                        r_done <= 1'b1;
                    end else begin
                        if (r_b[0]) begin
                            r_acc <= r_acc + r_a;
                        end
                        r_a <= r_a << 1;
                        r_b <= r_b >> 1;
                    end
                end else begin
                    r_rem <= ge ? WW'(rem_sh - {1'b0, r_b}) : rem_sh[WW-1:0];
                    r_a   <= {r_a[WW-2:0], ge};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(WW - 1)) begin
                        r_act  <= 1'b0;
                        r_done <= 1'b1;
                    end
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_result    = (r_op == MD_DIV) ? r_a : r_acc;

endmodule
`default_nettype wire

### rtl/lrf_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrf_back: fit sequencer
// Takes one sum snapshot at a time, forms variances, covariance and intercept
// numerator, divides and takes the root if status allows, holds the result.
// ----------------------------------------------------------------------------
module lrf_back #(
    parameter int N_W   = 11,
    parameter int S1_W  = 35,
    parameter int S2_W  = 59,
    parameter int WW    = 212,
    parameter int REC_W = 259
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [REC_W-1:0]    i_rec,
    input  wire logic                i_empty,
    output logic                     o_pop,
    output lrf_pkg::t_md_cmd         o_cmd,
    output logic [WW-1:0]            o_op_a,
    output logic [WW-1:0]            o_op_b,
    input  wire lrf_pkg::t_md_stat   i_stat,
    input  wire logic [WW-1:0]       i_result,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output logic signed [31:0]       o_correlation,
    output logic signed [47:0]       o_slope,
    output logic signed [47:0]       o_intercept,
    output logic [1:0]               o_fit_status
);
    import lrf_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE, ST_NXX, ST_SXX, ST_NYY, ST_SYY, ST_NXY, ST_SXY, ST_BA, ST_BB,
        ST_CHECK, ST_SLOPE, ST_ICPT, ST_PROD, ST_SQR, ST_QUOT, ST_SQRT, ST_OUT
    } t_state;

    t_state             r_state;
    logic               r_wait;
    logic               r_excess;
    logic [N_W-1:0]     r_n;
    logic [S1_W-1:0]    r_sx, r_sy;
    logic [S2_W-1:0]    r_sxx, r_syy, r_sxy;
    logic [WW-1:0]      r_t, r_dxx, r_dyy, r_dxy, r_bnum;
    logic               r_dneg, r_nneg;
    logic [OUT_W-1:0]   r_slope, r_icpt;
    t_fit_status        r_status;
    logic [Q_W-1:0]     r_sq_v;
    logic [SQ_REM_W-1:0] r_sq_rem;
    logic [31:0]        r_sq_root;
    logic [SQ_CNT_W-1:0] r_sq_cnt;
    logic               r_ov;
    logic [CORR_W-1:0]  r_o_corr;
    logic [OUT_W-1:0]   r_o_slope, r_o_icpt;
    t_fit_status        r_o_status;

    logic               h_excess;
    logic [N_W-1:0]     h_n;
    logic [S1_W-1:0]    h_sx, h_sy;
    logic [S2_W-1:0]    h_sxx, h_syy, h_sxy;
    logic               op_state;
    t_md_op             op_sel;
    logic               d_ge;
    logic [WW-1:0]      d_mag;
    logic [SQ_REM_W-1:0] sq_sh, sq_trial;
    logic               sq_ge;
    logic [32:0]        c_full;
    logic [31:0]        c_cap;
    logic               out_free;

    assign {h_excess, h_n, h_sx, h_sy, h_sxx, h_syy, h_sxy} = i_rec;

    // clamp a rounded Q32.16 quotient, apply sign
    function automatic logic [OUT_W-1:0] sat_q16(input logic [WW-1:0] q, input logic neg);
        logic [WW-1:0]    lim;
        logic [OUT_W-1:0] v;
        lim = neg ? (WW'(1) << SAT_BIT) : ((WW'(1) << SAT_BIT) - WW'(1));
        v   = (q > lim) ? lim[OUT_W-1:0] : q[OUT_W-1:0];
        return neg ? (OUT_W'(0) - v) : v;
    endfunction

    // operand selection for the shared unit
    always_comb begin
        op_state = 1'b1;
        op_sel   = MD_MUL;
        o_op_a   = '0;
        o_op_b   = '0;
        case (r_state)
            ST_NXX: begin o_op_a = WW'(r_n);  o_op_b = WW'(r_sxx); end
            ST_SXX: begin o_op_a = WW'(r_sx); o_op_b = WW'(r_sx);  end
            ST_NYY: begin o_op_a = WW'(r_n);  o_op_b = WW'(r_syy); end
            ST_SYY: begin o_op_a = WW'(r_sy); o_op_b = WW'(r_sy);  end
            ST_NXY: begin o_op_a = WW'(r_n);  o_op_b = WW'(r_sxy); end
            ST_SXY: begin o_op_a = WW'(r_sx); o_op_b = WW'(r_sy);  end
            ST_BA:  begin o_op_a = WW'(r_sy); o_op_b = WW'(r_sxx); end
            ST_BB:  begin o_op_a = WW'(r_sx); o_op_b = WW'(r_sxy); end
            ST_SLOPE: begin
                op_sel = MD_DIV;
                o_op_a = (r_dxy << FRAC_SHIFT) + r_dxx;
                o_op_b = r_dxx << 1;
            end
            ST_ICPT: begin
                op_sel = MD_DIV;
                o_op_a = (r_bnum << FRAC_SHIFT) + r_dxx;
                o_op_b = r_dxx << 1;
            end
            ST_PROD: begin o_op_a = r_dxx; o_op_b = r_dyy; end
            ST_SQR:  begin o_op_a = r_dxy; o_op_b = r_dxy; end
            ST_QUOT: begin
                op_sel = MD_DIV;
                o_op_a = r_bnum;
                o_op_b = r_t;
            end
            default: op_state = 1'b0;
        endcase
        o_cmd.start = op_state && !r_wait;
        o_cmd.op    = op_sel;
    end

    // signed difference of the held product and the new one
    always_comb begin
        d_ge  = r_t >= i_result;
        d_mag = d_ge ? r_t - i_result : i_result - r_t;
    end

    // root step and final correlation magnitude
    always_comb begin
        sq_sh    = {r_sq_rem[SQ_REM_W-3:0], r_sq_v[Q_W-1:Q_W-2]};
        sq_trial = SQ_REM_W'({r_sq_root, 2'b01});
        sq_ge    = sq_sh >= sq_trial;
        c_full   = ({1'b0, r_sq_root} + 33'd1) >> 1;
        c_cap    = (c_full > (33'd1 << CORR_ONE)) ? (32'd1 << CORR_ONE) : c_full[31:0];
    end

    assign out_free = !r_ov || !i_stall;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wait  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (r_ov && !i_stall) begin
                r_ov <= 1'b0;
            end
            if (o_cmd.start) begin
                r_wait <= 1'b1;
            end
            if (op_state && r_wait && i_stat.done) begin
                r_wait <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_excess <= h_excess;
                        r_n      <= h_n;
                        r_sx     <= h_sx;
                        r_sy     <= h_sy;
                        r_sxx    <= h_sxx;
                        r_syy    <= h_syy;
                        r_sxy    <= h_sxy;
                        r_state  <= ST_NXX;
                    end
                end
                ST_NXX, ST_NYY, ST_NXY, ST_BA: begin
                    if (r_wait && i_stat.done) begin
                        r_t     <= i_result;
                        r_state <= t_state'(r_state + 5'd1);
                    end
                end
                ST_SXX: begin
                    if (r_wait && i_stat.done) begin
                        r_dxx   <= d_mag;
                        r_state <= ST_NYY;
                    end
                end
                ST_SYY: begin
                    if (r_wait && i_stat.done) begin
                        r_dyy   <= d_mag;
                        r_state <= ST_NXY;
                    end
                end
                ST_SXY: begin
                    if (r_wait && i_stat.done) begin
                        r_dxy   <= d_mag;
                        r_dneg  <= !d_ge;
                        r_state <= ST_BA;
                    end
                end
                ST_BB: begin
                    if (r_wait && i_stat.done) begin
                        r_bnum  <= d_mag;
                        r_nneg  <= !d_ge;
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_slope  <= '0;
                    r_icpt   <= '0;
                    r_sq_root <= '0;
                    if (r_excess) begin
                        r_status <= FS_EXCESS;
                        r_state  <= ST_OUT;
                    end else if (r_dxx == '0) begin
                        r_status <= FS_X_CONST;
                        r_state  <= ST_OUT;
                    end else begin
                        r_status <= FS_OK;
                        r_state  <= ST_SLOPE;
                    end
                end
                ST_SLOPE: begin
                    if (r_wait && i_stat.done) begin
                        r_slope <= sat_q16(i_result, r_dneg);
                        r_state <= ST_ICPT;
                    end
                end
                ST_ICPT: begin
                    if (r_wait && i_stat.done) begin
                        r_icpt <= sat_q16(i_result, r_nneg);
                        if (r_dyy == '0) begin
                            r_status <= FS_Y_CONST;
                            r_state  <= ST_OUT;
                        end else begin
                            r_state <= ST_PROD;
                        end
                    end
                end
                ST_PROD: begin
                    if (r_wait && i_stat.done) begin
                        r_t     <= i_result;
                        r_state <= ST_SQR;
                    end
                end
                ST_SQR: begin
                    if (r_wait && i_stat.done) begin
                        r_bnum  <= i_result << CORR_SHIFT;
                        r_state <= ST_QUOT;
                    end
                end
                ST_QUOT: begin
                    if (r_wait && i_stat.done) begin
                        r_sq_v    <= i_result[Q_W-1:0];
                        r_sq_rem  <= '0;
                        r_sq_root <= '0;
                        r_sq_cnt  <= '0;
                        r_state   <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_sq_v    <= r_sq_v << 2;
                    r_sq_rem  <= sq_ge ? sq_sh - sq_trial : sq_sh;
                    r_sq_root <= {r_sq_root[30:0], sq_ge};
                    r_sq_cnt  <= r_sq_cnt + SQ_CNT_W'(1);
                    if (r_sq_cnt == SQ_CNT_W'(SQRT_STEPS - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ov       <= 1'b1;
                        r_o_corr   <= r_dneg ? CORR_W'(0) - c_cap : c_cap;
                        r_o_slope  <= r_slope;
                        r_o_icpt   <= r_icpt;
                        r_o_status <= r_status;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ov;
    assign o_correlation = r_o_corr;
    assign o_slope       = r_o_slope;
    assign o_intercept   = r_o_icpt;
    assign o_fit_status  = r_o_status;

endmodule
`default_nettype wire
